@@ rtl/core/wsb_pkg.sv @@
// Shared constants, types and codes of the warp scheduler with barriers.
package wsb_pkg;

   localparam int WARP_COUNT    = 16;
   localparam int BARRIER_SLOTS = 16;

   localparam int WARP_IDX_W  = $clog2(WARP_COUNT);
   localparam int SPAWN_CNT_W = $clog2(WARP_COUNT + 1);
   localparam int POP_W       = $clog2(WARP_COUNT + 1);
   localparam int BAR_ADDR_W  = (BARRIER_SLOTS > 1) ? $clog2(BARRIER_SLOTS) : 1;

   // Item kinds
   localparam logic [2:0] KIND_SCHEDULE = 3'd0;
   localparam logic [2:0] KIND_SUSPEND  = 3'd1;
   localparam logic [2:0] KIND_RESUME   = 3'd2;
   localparam logic [2:0] KIND_SPAWN    = 3'd3;
   localparam logic [2:0] KIND_BARRIER  = 3'd4;
   localparam logic [2:0] KIND_HALT     = 3'd5;

   typedef logic [WARP_COUNT-1:0] warp_mask_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  warp_id;
      logic        resume_all;
      logic [7:0]  spawn_count;
      logic [31:0] spawn_pc;
      logic [3:0]  barrier_index;
      logic        barrier_global;
      logic [7:0]  barrier_count;
   } item_type;

   typedef struct packed {
      warp_mask_type          active;
      warp_mask_type          stalled;
      logic                   spawn_pending;
      logic [SPAWN_CNT_W-1:0] spawn_warps;
      logic [31:0]            spawn_pc;
   } warp_state_type;

   typedef struct packed {
      logic        sched_valid;
      logic [3:0]  sched_warp;
      logic [15:0] spawned_mask;
      logic [31:0] spawn_start_pc;
      logic        proceed;
      logic        global_request;
      logic [3:0]  global_index;
      logic        running;
   } result_type;

endpackage

@@ rtl/core/wsb_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module wsb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/wsb_exec.sv @@
// Item execution: mask updates, spawn, barrier check and warp pick for one item.
module wsb_exec import wsb_pkg::*; (
   input  item_type       item,
   input  warp_state_type cur,
   input  warp_mask_type  arr_cur,
   output warp_state_type nxt,
   output logic           arr_we,
   output warp_mask_type  arr_nxt,
   output result_type     res
);

   function automatic logic [POP_W-1:0] popcount(input warp_mask_type m);
      logic [POP_W-1:0] n;
      n = '0;
      for (int i = 0; i < WARP_COUNT; i++) begin
         n = n + POP_W'(m[i]);
      end
      return n;
   endfunction

   warp_mask_type          wid_bit;
   warp_mask_type          spawn_fill;
   warp_mask_type          act_sched;
   warp_mask_type          stall_sched;
   warp_mask_type          ready_mask;
   warp_mask_type          arr_or;
   logic [POP_W-1:0]       pop_active;
   logic [POP_W-1:0]       pop_arr;
   logic                   single_active;
   logic                   spawn_go;
   logic [WARP_IDX_W-1:0]  pick;
   logic                   pick_valid;
   logic [SPAWN_CNT_W-1:0] spawn_n;
   logic                   bar_skip;

   // Decode warp bit, popcounts and spawn fill
   always_comb begin
      wid_bit = (32'(item.warp_id) < WARP_COUNT) ?
                (warp_mask_type'(1) << item.warp_id) : '0;
      pop_active    = popcount(cur.active);
      single_active = (pop_active == POP_W'(1));
      for (int i = 0; i < WARP_COUNT; i++) begin
         spawn_fill[i] = (i != 0) && (i < int'(cur.spawn_warps));
      end
      spawn_go    = (item.kind == KIND_SCHEDULE) && cur.spawn_pending && single_active;
      act_sched   = spawn_go ? (cur.active | spawn_fill) : cur.active;
      stall_sched = spawn_go ? (cur.stalled & ~warp_mask_type'(1)) : cur.stalled;
      ready_mask  = act_sched & ~stall_sched;
   end

   // Pick lowest ready warp
   always_comb begin
      pick       = '0;
      pick_valid = 1'b0;
      for (int w = WARP_COUNT - 1; w >= 0; w--) begin
         if (ready_mask[w]) begin
            pick       = WARP_IDX_W'(w);
            pick_valid = 1'b1;
         end
      end
   end

   // Clamp spawn count and evaluate barrier arrival
   always_comb begin
      spawn_n  = (32'(item.spawn_count) > WARP_COUNT) ?
                 SPAWN_CNT_W'(WARP_COUNT) : SPAWN_CNT_W'(item.spawn_count);
      bar_skip = (item.barrier_count < 8'd2) || (32'(item.barrier_index) >= BARRIER_SLOTS);
      arr_or   = arr_cur | wid_bit;
      pop_arr  = popcount(arr_or);
   end

   // Apply item to state and build result
   always_comb begin
      nxt     = cur;
      arr_we  = 1'b0;
      arr_nxt = arr_or;
      res     = '0;
      unique case (item.kind)
         KIND_SCHEDULE: begin
            nxt.active  = act_sched;
            nxt.stalled = stall_sched;
            if (spawn_go) begin
               nxt.spawn_pending  = 1'b0;
               res.spawned_mask   = 16'(spawn_fill);
               res.spawn_start_pc = cur.spawn_pc;
            end
            res.sched_valid = pick_valid;
            res.sched_warp  = 4'(pick);
         end
         KIND_SUSPEND: begin
            nxt.stalled = cur.stalled | wid_bit;
         end
         KIND_RESUME: begin
            nxt.stalled = item.resume_all ? '0 : (cur.stalled & ~wid_bit);
         end
         KIND_SPAWN: begin
            if ((spawn_n < SPAWN_CNT_W'(2)) && single_active) begin
               res.proceed = 1'b1;
            end else begin
               nxt.spawn_pending = 1'b1;
               nxt.spawn_warps   = spawn_n;
               nxt.spawn_pc      = item.spawn_pc;
            end
         end
         KIND_BARRIER: begin
            if (bar_skip) begin
               res.proceed = 1'b1;
            end else begin
               arr_we = 1'b1;
               if (item.barrier_global) begin
                  if (pop_arr == pop_active) begin
                     res.global_request = 1'b1;
                     res.global_index   = item.barrier_index;
                     arr_nxt            = '0;
                  end
               end else if (8'(pop_arr) == item.barrier_count) begin
                  nxt.stalled = cur.stalled & ~arr_or;
                  arr_nxt     = '0;
               end
            end
         end
         KIND_HALT: begin
            nxt.active = '0;
         end
         default: begin
            nxt = cur;
         end
      endcase
      res.running = |nxt.active;
   end

endmodule

@@ rtl/core/warp_scheduler_with_barriers.sv @@
// Top level of the warp scheduler with barriers: handshake, state registers, arrival RAM.
//
// Usage:
//   One item enters on the req_ channel (valid/ready); every item yields exactly
//   one result on the rsp_ channel (valid/ready), in order.
//   Item kinds: schedule, suspend, resume, spawn, barrier arrival, halt.
//   An accepted item is registered and executed; its result is registered in
//   the output register, which drives rsp_valid. No new item is accepted until
//   the previous one commits. The barrier arrival masks live in a RAM with
//   registered read data; each item reads its entry on acceptance and writes it
//   back on commit, with req_ready low in between so no two accesses to an entry overlap.
//   The result sits in an output register; the next item is accepted while it
//   waits. If rsp_ready stays low, the following item is held in its execute
//   cycle until the output register frees up.
//   Reset: warp 0 active, nothing stalled, no spawn pending, and all barrier
//   entries read as empty (per-entry valid bits, cleared at once; no clear pass).
module warp_scheduler_with_barriers import wsb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [3:0]  req_warp_id,
   input  logic        req_resume_all,
   input  logic [7:0]  req_spawn_count,
   input  logic [31:0] req_spawn_pc_in,
   input  logic [3:0]  req_barrier_index,
   input  logic        req_barrier_global,
   input  logic [7:0]  req_barrier_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_sched_valid,
   output logic [3:0]  rsp_sched_warp,
   output logic [15:0] rsp_spawned_mask,
   output logic [31:0] rsp_spawn_start_pc,
   output logic        rsp_proceed,
   output logic        rsp_global_request,
   output logic [3:0]  rsp_global_index,
   output logic        rsp_running
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } ctl_state_type;

   ctl_state_type     state_ff, state_in;
   item_type          item_ff;
   warp_state_type    ws_ff, ws_in;
   logic [BARRIER_SLOTS-1:0] bar_valid_ff, bar_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff;

   logic                  accept;
   logic                  commit;
   logic [BAR_ADDR_W-1:0] rd_addr;
   logic [BAR_ADDR_W-1:0] wr_addr;
   warp_mask_type         ram_rd_data;
   warp_mask_type         arr_cur;
   warp_mask_type         arr_nxt;
   logic                  arr_we;
   logic                  ram_we;
   result_type            res;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign commit    = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign rd_addr   = BAR_ADDR_W'(req_barrier_index);
   assign wr_addr   = BAR_ADDR_W'(item_ff.barrier_index);
   assign ram_we    = commit && arr_we;
   assign arr_cur   = bar_valid_ff[wr_addr] ? ram_rd_data : '0;

   wsb_ram #(
      .WIDTH (WARP_COUNT),
      .DEPTH (BARRIER_SLOTS)
   ) u_arr_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_addr),
      .wr_data (arr_nxt),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   wsb_exec u_exec (
      .item    (item_ff),
      .cur     (ws_ff),
      .arr_cur (arr_cur),
      .nxt     (ws_in),
      .arr_we  (arr_we),
      .arr_nxt (arr_nxt),
      .res     (res)
   );

   // Sequence: idle until accept, execute until the output register is free
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (commit) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output valid and barrier entry valid bits
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      bar_valid_in = bar_valid_ff;
      if (ram_we) begin
         bar_valid_in[wr_addr] = 1'b1;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         rsp_valid_ff      <= 1'b0;
         bar_valid_ff      <= '0;
         ws_ff.active      <= warp_mask_type'(1);
         ws_ff.stalled     <= '0;
         ws_ff.spawn_pending <= 1'b0;
         ws_ff.spawn_warps <= '0;
         ws_ff.spawn_pc    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bar_valid_ff <= bar_valid_in;
         if (commit) begin
            ws_ff <= ws_in;
         end
      end
   end

   // Capture item and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.kind           <= req_kind;
         item_ff.warp_id        <= req_warp_id;
         item_ff.resume_all     <= req_resume_all;
         item_ff.spawn_count    <= req_spawn_count;
         item_ff.spawn_pc       <= req_spawn_pc_in;
         item_ff.barrier_index  <= req_barrier_index;
         item_ff.barrier_global <= req_barrier_global;
         item_ff.barrier_count  <= req_barrier_count;
      end
      if (commit) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sched_valid    = rsp_ff.sched_valid;
   assign rsp_sched_warp     = rsp_ff.sched_warp;
   assign rsp_spawned_mask   = rsp_ff.spawned_mask;
   assign rsp_spawn_start_pc = rsp_ff.spawn_start_pc;
   assign rsp_proceed        = rsp_ff.proceed;
   assign rsp_global_request = rsp_ff.global_request;
   assign rsp_global_index   = rsp_ff.global_index;
   assign rsp_running        = rsp_ff.running;

endmodule

@@ rtl/core/wsb_checker.sv @@
// Port-level checker for the warp scheduler with barriers, bound to the top level.
module wsb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_sched_valid,
   input logic [3:0]  rsp_sched_warp,
   input logic [15:0] rsp_spawned_mask,
   input logic        rsp_proceed,
   input logic        rsp_global_request,
   input logic [3:0]  rsp_global_index
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sched_warp)
         && $stable(rsp_spawned_mask) && $stable(rsp_global_index))
      else $error("result changed while stalled");

   // Only one item in flight: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while previous one executes");

   // An accepted item is followed by a valid result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> ##1 rsp_valid)
      else $error("result missing after accepted item");

   // A schedule result never also reports proceed or a global request
   a_sched_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sched_valid |-> !rsp_proceed && !rsp_global_request)
      else $error("schedule result mixed with barrier or spawn outcome");

   // Global index is zero without a global request
   a_gidx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_global_request |-> rsp_global_index == 4'd0)
      else $error("global index set without request");

endmodule

bind warp_scheduler_with_barriers wsb_checker u_wsb_checker (.*);
